FILE: src/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared widths, types and constants of the vertex normal block.
// ----------------------------------------------------------------------------
`default_nettype none
package vnf_pkg;
    localparam int SUM_W      = 40;
    localparam int CROSS_W    = 34;
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 62;
    localparam int LEN_W      = 31;
    localparam int ONE_Q14    = 16384;
    localparam int MAX_TRI_DEF = 16;

    // kind of beat handed to the back part
    typedef enum logic [1:0] {
        OP_ADD,
        OP_ADD_LAST,
        OP_EMPTY
    } op_t;

    // one triangle beat after the front part
    typedef struct packed {
        op_t                        op;
        logic [15:0]                tag;
        logic signed [CROSS_W-1:0]  cx;
        logic signed [CROSS_W-1:0]  cy;
        logic signed [CROSS_W-1:0]  cz;
    } job_t;

    // saturating add of one cross component into a sum
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]   s,
        input logic signed [CROSS_W-1:0] c
    );
        logic signed [SUM_W:0] r;
        logic signed [SUM_W:0] hi;
        logic signed [SUM_W:0] lo;
        begin
            hi = {2'b00, {(SUM_W-1){1'b1}}};
            lo = {2'b11, {(SUM_W-1){1'b0}}};
            r  = {s[SUM_W-1], s} + {{(SUM_W+1-CROSS_W){c[CROSS_W-1]}}, c};
            if (r > hi)
                sat_add = hi[SUM_W-1:0];
            else if (r < lo)
                sat_add = lo[SUM_W-1:0];
            else
                sat_add = r[SUM_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

FILE: src/vnf_front.sv
// ----------------------------------------------------------------------------
// vnf_front
// Accepts triangle beats, forms the cross product over two stages and
// classifies each beat.
// ----------------------------------------------------------------------------
`default_nettype none
module vnf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [15:0]   tag,
    input  wire logic [15:0]   ax,
    input  wire logic [15:0]   ay,
    input  wire logic [15:0]   az,
    input  wire logic [15:0]   bx,
    input  wire logic [15:0]   by_coord,
    input  wire logic [15:0]   bz,
    input  wire logic [15:0]   cx,
    input  wire logic [15:0]   cy,
    input  wire logic [15:0]   cz,
    input  wire logic          last,
    input  wire logic          empty,
    output logic               job_valid,
    output vnf_pkg::job_t      job,
    input  wire logic          job_stall
);
    import vnf_pkg::*;

    // stage 1: edge vectors
    logic                      s1_valid_reg;
    op_t                       s1_op_reg;
    logic [15:0]               s1_tag_reg;
    logic signed [16:0]        ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    // stage 2: products
    logic                      s2_valid_reg;
    op_t                       s2_op_reg;
    logic [15:0]               s2_tag_reg;
    logic signed [33:0]        p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    logic adv2, adv1;
    assign adv2     = !s2_valid_reg || !job_stall;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    // output beat, difference of products
    assign job_valid = s2_valid_reg;
    always_comb
    begin
        job.op  = s2_op_reg;
        job.tag = s2_tag_reg;
        job.cx  = p0_reg - p1_reg;
        job.cy  = p2_reg - p3_reg;
        job.cz  = p4_reg - p5_reg;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_tag_reg <= tag;
            if (empty)
                s1_op_reg <= OP_EMPTY;
            else if (last)
                s1_op_reg <= OP_ADD_LAST;
            else
                s1_op_reg <= OP_ADD;
            ux_reg <= $signed({bx[15], bx})       - $signed({ax[15], ax});
            uy_reg <= $signed({by_coord[15], by_coord}) - $signed({ay[15], ay});
            uz_reg <= $signed({bz[15], bz})       - $signed({az[15], az});
            vx_reg <= $signed({cx[15], cx})       - $signed({ax[15], ax});
            vy_reg <= $signed({cy[15], cy})       - $signed({ay[15], ay});
            vz_reg <= $signed({cz[15], cz})       - $signed({az[15], az});
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_tag_reg <= s1_tag_reg;
            s2_op_reg  <= s1_op_reg;
            p0_reg <= uy_reg * vz_reg;
            p1_reg <= uz_reg * vy_reg;
            p2_reg <= uz_reg * vx_reg;
            p3_reg <= ux_reg * vz_reg;
            p4_reg <= ux_reg * vy_reg;
            p5_reg <= uy_reg * vx_reg;
        end
    end
endmodule
`default_nettype wire

FILE: src/vnf_fifo.sv
// ----------------------------------------------------------------------------
// vnf_fifo
// Short queue of job beats between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module vnf_fifo (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_valid,
    input  vnf_pkg::job_t  wr_data,
    output logic           wr_stall,
    output logic           rd_valid,
    output vnf_pkg::job_t  rd_data,
    input  wire logic      rd_take
);
    import vnf_pkg::*;

    job_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_stall = (cnt_reg == 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_take && rd_valid;

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b00, wr_en} - {2'b00, rd_en};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

FILE: src/vnf_back.sv
// ----------------------------------------------------------------------------
// vnf_back
// Accumulates face normals and normalises the sum with an iterative square
// root and a shared restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module vnf_back #(
    parameter int MAX_TRIANGLES = vnf_pkg::MAX_TRI_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  vnf_pkg::job_t      job,
    output logic               job_take,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [15:0]        out_tag,
    output logic [15:0]        normal_x,
    output logic [15:0]        normal_y,
    output logic [15:0]        normal_z,
    output logic               degenerate
);
    import vnf_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
    localparam int NUM_W = MAG_W + 16;   // 2*m*16384 + len

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAG, ST_SHIFT, ST_SQ, ST_SUMSQ, ST_SQRT, ST_DIVSET, ST_DIV,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    logic signed [SUM_W-1:0]   sx_reg, sy_reg, sz_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [15:0]               tag_reg;
    logic [2:0]                neg_reg;
    logic [SUM_W-1:0]          mx_reg, my_reg, mz_reg;
    logic [SQ_W-1:0]           qx_reg, qy_reg, qz_reg;
    logic [SQ_W+1:0]           n_reg;
    logic [SQ_W+1:0]           root_reg;
    logic [SQ_W+1:0]           bit_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [1:0]                comp_reg;
    logic [5:0]                step_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          quo_reg;
    logic [LEN_W+1:0]          rem_reg;
    logic                      out_valid_reg;
    logic [15:0]               nx_reg, ny_reg, nz_reg;
    logic                      deg_reg;

    assign out_valid  = out_valid_reg;
    assign out_tag    = tag_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = deg_reg;

    // take a job only when idle and the result slot is free
    assign job_take = (state_reg == ST_IDLE) && !(out_valid_reg && out_stall);

    // a result is loaded on an empty beat or when normalising ends
    logic res_load;
    assign res_load = ((state_reg == ST_IDLE) && job_valid && job_take
                       && (job.op == OP_EMPTY))
                   || ((state_reg == ST_DONE) && !(out_valid_reg && out_stall));

    // accumulated values for this beat
    logic signed [SUM_W-1:0] ax_n, ay_n, az_n;
    logic                    add_ok;
    assign add_ok = ({1'b0, cnt_reg} < (CNT_W+1)'(MAX_TRIANGLES));
    assign ax_n   = add_ok ? sat_add(sx_reg, job.cx) : sx_reg;
    assign ay_n   = add_ok ? sat_add(sy_reg, job.cy) : sy_reg;
    assign az_n   = add_ok ? sat_add(sz_reg, job.cz) : sz_reg;

    // magnitude helpers
    logic [SUM_W-1:0] big;
    always_comb
    begin
        big = mx_reg;
        if (my_reg > big)
            big = my_reg;
        if (mz_reg > big)
            big = mz_reg;
    end

    // sqrt step
    logic [SQ_W+1:0] rb;
    assign rb = root_reg + bit_reg;

    // divider step: remainder doubled plus next numerator bit
    logic [LEN_W+1:0] rem_sh;
    logic [LEN_W+1:0] den;
    assign rem_sh = {rem_reg[LEN_W:0], num_reg[NUM_W-1]};
    assign den    = {1'b0, len_reg, 1'b0};

    // quotient clamp and sign
    logic [15:0] qv;
    logic        qneg;
    always_comb
    begin
        if (quo_reg > NUM_W'(ONE_Q14))
            qv = 16'(ONE_Q14);
        else
            qv = quo_reg[15:0];
        case (comp_reg)
            2'd0:    qneg = neg_reg[0];
            2'd1:    qneg = neg_reg[1];
            default: qneg = neg_reg[2];
        endcase
        if (qneg)
            qv = 16'd0 - qv;
    end

    logic [MAG_W-1:0] msel;
    always_comb
    begin
        case (comp_reg)
            2'd0:    msel = mx_reg[MAG_W-1:0];
            2'd1:    msel = my_reg[MAG_W-1:0];
            default: msel = mz_reg[MAG_W-1:0];
        endcase
    end

    // control sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid && job_take)
                    begin
                        tag_reg <= job.tag;
                        if (job.op == OP_EMPTY)
                        begin
                            sx_reg <= '0; sy_reg <= '0; sz_reg <= '0;
                            cnt_reg <= '0;
                            nx_reg <= '0; ny_reg <= '0; nz_reg <= '0;
                            deg_reg <= 1'b0;
                        end
                        else if (job.op == OP_ADD)
                        begin
                            sx_reg <= ax_n; sy_reg <= ay_n; sz_reg <= az_n;
                            if (add_ok)
                                cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            sx_reg <= ax_n; sy_reg <= ay_n; sz_reg <= az_n;
                            state_reg <= ST_MAG;
                        end
                    end
                end
                ST_MAG:
                begin
                    neg_reg <= {sz_reg[SUM_W-1], sy_reg[SUM_W-1], sx_reg[SUM_W-1]};
                    mx_reg <= sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : sx_reg;
                    my_reg <= sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : sy_reg;
                    mz_reg <= sz_reg[SUM_W-1] ? SUM_W'(-sz_reg) : sz_reg;
                    sx_reg <= '0; sy_reg <= '0; sz_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT:
                begin
                    // one bit of right shift per cycle until below 2^30
                    if (big == '0)
                    begin
                        nx_reg <= '0; ny_reg <= '0; nz_reg <= '0;
                        deg_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else if (big[SUM_W-1:MAG_W] != '0)
                    begin
                        mx_reg <= mx_reg >> 1;
                        my_reg <= my_reg >> 1;
                        mz_reg <= mz_reg >> 1;
                    end
                    else
                        state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    qx_reg <= mx_reg[MAG_W-1:0] * mx_reg[MAG_W-1:0];
                    qy_reg <= my_reg[MAG_W-1:0] * my_reg[MAG_W-1:0];
                    qz_reg <= mz_reg[MAG_W-1:0] * mz_reg[MAG_W-1:0];
                    state_reg <= ST_SUMSQ;
                end
                ST_SUMSQ:
                begin
                    n_reg     <= {2'b00, qx_reg} + {2'b00, qy_reg} + {2'b00, qz_reg};
                    root_reg  <= '0;
                    bit_reg   <= (SQ_W+2)'(1) << (SQ_W);
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        len_reg   <= (root_reg == '0) ? LEN_W'(1) : root_reg[LEN_W-1:0];
                        comp_reg  <= 2'd0;
                        state_reg <= ST_DIVSET;
                    end
                    else
                    begin
                        if (n_reg >= rb)
                        begin
                            n_reg    <= n_reg - rb;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                            root_reg <= root_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                ST_DIVSET:
                begin
                    num_reg   <= {1'b0, msel, 15'd0} + NUM_W'(len_reg);
                    quo_reg   <= '0;
                    rem_reg   <= '0;
                    step_reg  <= 6'(NUM_W);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == 6'd0)
                    begin
                        case (comp_reg)
                            2'd0:    nx_reg <= qv;
                            2'd1:    ny_reg <= qv;
                            default: nz_reg <= qv;
                        endcase
                        if (comp_reg == 2'd2)
                        begin
                            deg_reg   <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_DIVSET;
                        end
                    end
                    else
                    begin
                        num_reg <= num_reg << 1;
                        if (rem_sh >= den)
                        begin
                            rem_reg <= rem_sh - den;
                            quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                        end
                        step_reg <= step_reg - 6'd1;
                    end
                end
                ST_DONE:
                begin
                    if (!(out_valid_reg && out_stall))
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/vertex_normal_from_faces.sv
// ----------------------------------------------------------------------------
// vertex_normal_from_faces
// Averaged vertex normal from the triangles around one vertex, Q2.14 out.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | vertex_tag, ax..cz, last_triangle, empty_vertex
//  out     | out_valid / out_stall | out_tag, normal_x/y/z, degenerate
//
//  A plain triangle beat is folded into the accumulator while the back part is
//  idle; the front part takes one beat per cycle, unless the queue stalls it,
//  through a two-stage cross product. A last beat runs the normaliser: up to 10
//  right shifts, 32 square root steps and three divides on one shared divider.
//  Reset clears the sums and queue; each side stalls on its own via the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_normal_from_faces #(
    parameter int MAX_TRIANGLES = vnf_pkg::MAX_TRI_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] vertex_tag,
    input  wire logic [15:0] ax,
    input  wire logic [15:0] ay,
    input  wire logic [15:0] az,
    input  wire logic [15:0] bx,
    input  wire logic [15:0] by_coord,
    input  wire logic [15:0] bz,
    input  wire logic [15:0] cx,
    input  wire logic [15:0] cy,
    input  wire logic [15:0] cz,
    input  wire logic        last_triangle,
    input  wire logic        empty_vertex,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      out_tag,
    output logic [15:0]      normal_x,
    output logic [15:0]      normal_y,
    output logic [15:0]      normal_z,
    output logic             degenerate
);
    import vnf_pkg::*;

    logic  f_valid, f_stall, q_valid, q_take;
    job_t  f_job, q_job;

    // front part
    vnf_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .tag(vertex_tag), .ax(ax), .ay(ay), .az(az),
        .bx(bx), .by_coord(by_coord), .bz(bz),
        .cx(cx), .cy(cy), .cz(cz),
        .last(last_triangle), .empty(empty_vertex),
        .job_valid(f_valid), .job(f_job), .job_stall(f_stall)
    );

    // job queue
    vnf_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_data(f_job), .wr_stall(f_stall),
        .rd_valid(q_valid), .rd_data(q_job), .rd_take(q_take)
    );

    // back part
    vnf_back #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job(q_job), .job_take(q_take),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_tag(out_tag), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .degenerate(degenerate)
    );
endmodule
`default_nettype wire

FILE: verif/vnf_checker.sv
// ----------------------------------------------------------------------------
// vnf_checker
// Watches both channels of the vertex normal block, predicts each normal
// from the accepted triangle beats and compares it with the result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vnf_checker #(
    parameter int MAX_TRIANGLES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [15:0] vertex_tag,
    input  wire logic [15:0] ax,
    input  wire logic [15:0] ay,
    input  wire logic [15:0] az,
    input  wire logic [15:0] bx,
    input  wire logic [15:0] by_coord,
    input  wire logic [15:0] bz,
    input  wire logic [15:0] cx,
    input  wire logic [15:0] cy,
    input  wire logic [15:0] cz,
    input  wire logic        last_triangle,
    input  wire logic        empty_vertex,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [15:0] out_tag,
    input  wire logic [15:0] normal_x,
    input  wire logic [15:0] normal_y,
    input  wire logic [15:0] normal_z,
    input  wire logic        degenerate,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -64'sd549755813888;

    normal_t normals_due[$];
    longint  acc_x, acc_y, acc_z;
    int      tri_taken;

    assign pending = normals_due.size();

    function automatic longint clip_sum(longint s, longint c);
        longint r;
        begin
            r = s + c;
            if (r > SUM_HI) r = SUM_HI;
            if (r < SUM_LO) r = SUM_LO;
            return r;
        end
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        begin
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        end
    endfunction

    function automatic logic [15:0] unit_comp(longint unsigned m, longint unsigned len,
                                              bit neg);
        longint unsigned q;
        begin
            q = (2 * m * 16384 + len) / (2 * len);
            if (q > 16384) q = 16384;
            return neg ? 16'(-q) : 16'(q);
        end
    endfunction

    function automatic longint unsigned abs_sum(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // fold one accepted triangle beat into the sums, queue a normal on last
    task automatic take_triangle();
        normal_t         n;
        longint          ux, uy, uz, vx, vy, vz;
        longint unsigned mx, my, mz, big, len;
        int              k;
        begin
            n = '0;
            n.tag = vertex_tag;
            if (empty_vertex)
            begin
                acc_x = 0; acc_y = 0; acc_z = 0; tri_taken = 0;
                normals_due = {normals_due, n};
                return;
            end
            if (tri_taken < MAX_TRIANGLES)
            begin
                ux = longint'($signed(bx)) - longint'($signed(ax));
                uy = longint'($signed(by_coord)) - longint'($signed(ay));
                uz = longint'($signed(bz)) - longint'($signed(az));
                vx = longint'($signed(cx)) - longint'($signed(ax));
                vy = longint'($signed(cy)) - longint'($signed(ay));
                vz = longint'($signed(cz)) - longint'($signed(az));
                acc_x = clip_sum(acc_x, uy * vz - uz * vy);
                acc_y = clip_sum(acc_y, uz * vx - ux * vz);
                acc_z = clip_sum(acc_z, ux * vy - uy * vx);
                tri_taken++;
            end
            if (!last_triangle) return;
            mx = abs_sum(acc_x); my = abs_sum(acc_y); mz = abs_sum(acc_z);
            big = mx;
            if (my > big) big = my;
            if (mz > big) big = mz;
            if (big == 0)
                n.degen = 1'b1;
            else
            begin
                k = 0;
                while ((big >> k) >= (64'd1 << 30)) k++;
                mx = mx >> k; my = my >> k; mz = mz >> k;
                len = floor_sqrt(mx * mx + my * my + mz * mz);
                if (len == 0) len = 1;
                n.nx = unit_comp(mx, len, acc_x < 0);
                n.ny = unit_comp(my, len, acc_y < 0);
                n.nz = unit_comp(mz, len, acc_z < 0);
            end
            acc_x = 0; acc_y = 0; acc_z = 0; tri_taken = 0;
            normals_due = {normals_due, n};
        end
    endtask

    // compare one result beat with the oldest predicted normal
    task automatic check_normal();
        normal_t w;
        begin
            if (normals_due.size() == 0)
            begin
                report_mismatch("unexpected out_tag", out_tag, 16'h0000);
                return;
            end
            w = normals_due.pop_front();
            if (out_tag !== w.tag) report_mismatch("out_tag", out_tag, w.tag);
            if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
            if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
            if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
            if (degenerate !== w.degen)
                report_mismatch("degenerate", 16'(degenerate), 16'(w.degen));
        end
    endtask

    initial
    begin
        fail_count = 0;
        acc_x = 0; acc_y = 0; acc_z = 0; tri_taken = 0;
    end

    // sample both channels at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) take_triangle();
            if (out_valid && !out_stall) check_normal();
        end
    end
endmodule

FILE: verif/vertex_normal_from_faces_tb.sv
// ----------------------------------------------------------------------------
// vertex_normal_from_faces_tb
// Drives triangle groups into the vertex normal block with random gaps and
// back-pressure; the checker predicts and compares every normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vertex_normal_from_faces_tb;
    import vnf_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] vertex_tag = '0;
    logic [15:0] ax = '0, ay = '0, az = '0;
    logic [15:0] bx = '0, by_coord = '0, bz = '0;
    logic [15:0] cx = '0, cy = '0, cz = '0;
    logic        last_triangle = 1'b0;
    logic        empty_vertex = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [15:0] out_tag, normal_x, normal_y, normal_z;
    logic        degenerate;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          sending_done = 1'b0;

    vertex_normal_from_faces dut (.*);

    vnf_checker #(.MAX_TRIANGLES(MAX_TRI_DEF)) u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // count cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall per beat, or a long hold-off when asked
    initial
    begin
        int w;
        repeat (6) @(posedge clk);
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
                if (w > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (w) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one triangle beat and wait until it is taken; valid stays high
    // after the beat until the next call or the caller drops it
    task automatic send_triangle(logic [15:0] tag, logic [15:0] c [9], bit lst, bit emp,
                                 bit gaps);
        int w;
        begin
            w = 0;
            if (gaps)
                w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
            if (w > 0)
            begin
                in_valid <= 1'b0;
                repeat (w) @(posedge clk);
            end
            vertex_tag <= tag;
            ax <= c[0]; ay <= c[1]; az <= c[2];
            bx <= c[3]; by_coord <= c[4]; bz <= c[5];
            cx <= c[6]; cy <= c[7]; cz <= c[8];
            last_triangle <= lst;
            empty_vertex <= emp;
            in_valid <= 1'b1;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
    endtask

    task automatic send_group(int ntri, bit gaps);
        logic [15:0] c [9];
        logic [15:0] tag;
        begin
            tag = 16'($urandom);
            for (int t = 0; t < ntri; t++)
            begin
                foreach (c[j]) c[j] = rand_coord();
                send_triangle(tag, c, t == ntri - 1, 1'b0, gaps);
            end
        end
    endtask

    initial
    begin
        logic [15:0] c [9];
        int          ntri;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unit triangle in xy plane gives +z
        c = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
              16'h0000, 16'h0100, 16'h0000};
        send_triangle(16'h0000, c, 1'b1, 1'b0, 1'b0);
        // flipped winding gives -z
        c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
              16'h0100, 16'h0000, 16'h0000};
        send_triangle(16'hffff, c, 1'b1, 1'b0, 1'b0);
        // collinear points give a degenerate normal
        c = '{16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h0200,
              16'h0300, 16'h0300, 16'h0300};
        send_triangle(16'h1234, c, 1'b1, 1'b0, 1'b0);
        // empty vertex wins over last, with junk coordinates
        c = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
              16'h8000, 16'h7fff, 16'h8000};
        send_triangle(16'h5a5a, c, 1'b1, 1'b1, 1'b0);
        send_triangle(16'ha5a5, c, 1'b0, 1'b1, 1'b0);
        // extreme coordinates over a group longer than the triangle limit
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
              16'h8000, 16'h7fff, 16'h7fff};
        for (int t = 0; t < 18; t++)
            send_triangle(16'h00ff, c, t == 17, 1'b0, 1'b0);

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        for (int g = 0; g < 20; g++)
            send_group($urandom_range(1, 3), 1'b0);
        // sender pause until every normal has arrived
        in_valid <= 1'b0;
        while (pending != 0 || hold_off) @(posedge clk);

        // random groups, mostly small, a few beyond the triangle limit
        for (int items = 0; items < 700; items += ntri)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                foreach (c[j]) c[j] = 16'($urandom);
                send_triangle(16'($urandom), c, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
                ntri = 1;
            end
            else
            begin
                ntri = $urandom_range(0, 10) == 0 ? $urandom_range(15, 20)
                                                   : $urandom_range(1, 5);
                send_group(ntri, $urandom_range(0, 3) != 0);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
